@@ rtl/clnws_pkg.sv @@
package clnws_pkg;

  // Request kinds as they arrive on the slave-side tuser field.
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_CMD  = 2'd1,
    OP_DATA = 2'd2,
    OP_INIT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_HIGH   = 3'd2,
    PH_LOW    = 3'd3,
    PH_SINGLE = 3'd4
  } phase_e;

  localparam int unsigned OpW   = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;
  localparam int unsigned WaitW = 5;
  localparam int unsigned StepW = 4;

  localparam logic [WaitW-1:0] POWER_ON_WAIT_MS = WaitW'(30);
  localparam logic [WaitW-1:0] WAIT_LONG_MS     = WaitW'(4);
  localparam logic [WaitW-1:0] WAIT_SHORT_MS    = WaitW'(1);
  localparam logic [WaitW-1:0] WAIT_FIRST_MS    = WaitW'(10);
  localparam logic [StepW-1:0] INIT_STEPS       = StepW'(8);
  localparam logic [StepW-1:0] INIT_NIBBLES     = StepW'(4);
  localparam logic [StepW-1:0] INIT_LAST_NIBBLE = StepW'(3);

  localparam logic [ByteW-1:0] INIT_NIB_WAKE = 8'h30;
  localparam logic [ByteW-1:0] INIT_NIB_4BIT = 8'h20;

  // Commands with a code below this limit need the long settle time.
  localparam logic [ByteW-1:0] SLOW_CMD_LIMIT = 8'h04;

  // Two-entry queue between the front and the back; depth is a power of two.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  // Padded widths of the stream data fields.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] byte_value;
  } item_t;

  function automatic logic [ByteW-1:0] init_cmd(input logic [1:0] idx);
    logic [ByteW-1:0] cmd;
    case (idx)
      2'd0:    cmd = 8'h28;
      2'd1:    cmd = 8'h06;
      2'd2:    cmd = 8'h01;
      default: cmd = 8'h0F;
    endcase
    return cmd;
  endfunction

endpackage

@@ rtl/clnws_front.sv @@
module clnws_front (
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [clnws_pkg::InDataW-1:0]     s_axis_tdata_i,
  input  logic [clnws_pkg::OpW-1:0]         s_axis_tuser_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output clnws_pkg::item_t                  q_item_o
);

  // Requests are taken whenever the queue has room; the op code is typed here.
  assign s_axis_tready_o     = !q_full_i;
  assign q_push_o            = s_axis_tvalid_i && !q_full_i;
  assign q_item_o.op         = clnws_pkg::op_e'(s_axis_tuser_i);
  assign q_item_o.byte_value = s_axis_tdata_i[clnws_pkg::ByteW-1:0];

endmodule

@@ rtl/clnws_queue.sv @@
module clnws_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  clnws_pkg::item_t item_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output clnws_pkg::item_t item_o
);

  clnws_pkg::item_t                 mem_q [clnws_pkg::QueueDepth];
  logic [clnws_pkg::QueueAw-1:0]    wr_ptr_q, wr_ptr_d;
  logic [clnws_pkg::QueueAw-1:0]    rd_ptr_q, rd_ptr_d;
  logic [clnws_pkg::QueueAw:0]      count_q, count_d;
  logic                             do_pop;

  assign full_o  = (count_q == (clnws_pkg::QueueAw+1)'(clnws_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ rtl/clnws_back.sv @@
module clnws_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  clnws_pkg::item_t               q_item_i,
  output logic                           q_pop_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [clnws_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                           m_axis_tuser_o
);

  clnws_pkg::phase_e                phase_q, phase_d;
  logic [clnws_pkg::WaitW-1:0]      wait_q, wait_d;
  logic [clnws_pkg::ByteW-1:0]      byte_q, byte_d;
  logic                             rs_q, rs_d;
  logic [clnws_pkg::StepW-1:0]      step_q, step_d;
  logic                             in_init_q, in_init_d;
  logic                             out_valid_q;
  logic [clnws_pkg::OutDataW-1:0]   out_data_q, out_data_d;
  logic                             out_user_q, out_user_d;
  logic                             take;
  logic                             idle;
  logic                             rejected;
  logic [clnws_pkg::NibW-1:0]       nib;
  logic                             en;
  logic                             busy;

  assign q_pop_o         = !out_valid_q || m_axis_tready_i;
  assign take            = q_pop_o && q_valid_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  always_comb begin
    phase_d   = phase_q;
    wait_d    = wait_q;
    byte_d    = byte_q;
    rs_d      = rs_q;
    step_d    = step_q;
    in_init_d = in_init_q;
    rejected  = 1'b0;
    idle      = (phase_q == clnws_pkg::PH_IDLE);

    if (q_item_i.op == clnws_pkg::OP_TICK) begin
      case (phase_q)
        clnws_pkg::PH_WAIT: begin
          if (wait_q <= clnws_pkg::WaitW'(1)) begin
            wait_d = '0;
            // End of a wait: during init the next step starts in this same tick; otherwise idle.
            if (in_init_q && step_q < clnws_pkg::INIT_STEPS) begin
              step_d = step_q + 1'b1;
              rs_d   = 1'b0;
              if (step_q < clnws_pkg::INIT_NIBBLES) begin
                byte_d  = (step_q == clnws_pkg::INIT_LAST_NIBBLE) ?
                          clnws_pkg::INIT_NIB_4BIT : clnws_pkg::INIT_NIB_WAKE;
                phase_d = clnws_pkg::PH_SINGLE;
              end else begin
                byte_d  = clnws_pkg::init_cmd(step_q[1:0]);
                phase_d = clnws_pkg::PH_HIGH;
              end
            end else begin
              in_init_d = 1'b0;
              step_d    = '0;
              phase_d   = clnws_pkg::PH_IDLE;
            end
          end else begin
            wait_d = wait_q - 1'b1;
          end
        end
        clnws_pkg::PH_HIGH: begin
          phase_d = clnws_pkg::PH_LOW;
        end
        clnws_pkg::PH_LOW: begin
          phase_d = clnws_pkg::PH_WAIT;
          wait_d  = (!rs_q && byte_q < clnws_pkg::SLOW_CMD_LIMIT) ?
                    clnws_pkg::WAIT_LONG_MS : clnws_pkg::WAIT_SHORT_MS;
        end
        clnws_pkg::PH_SINGLE: begin
          phase_d = clnws_pkg::PH_WAIT;
          wait_d  = (step_q == clnws_pkg::StepW'(1)) ?
                    clnws_pkg::WAIT_FIRST_MS : clnws_pkg::WAIT_SHORT_MS;
        end
        default: begin
          phase_d = clnws_pkg::PH_IDLE;
        end
      endcase
    end else if (!idle) begin
      rejected = 1'b1;
    end else begin
      case (q_item_i.op)
        clnws_pkg::OP_CMD: begin
          byte_d  = q_item_i.byte_value;
          rs_d    = 1'b0;
          phase_d = clnws_pkg::PH_HIGH;
        end
        clnws_pkg::OP_DATA: begin
          byte_d  = q_item_i.byte_value;
          rs_d    = 1'b1;
          phase_d = clnws_pkg::PH_HIGH;
        end
        default: begin
          in_init_d = 1'b1;
          step_d    = '0;
          phase_d   = clnws_pkg::PH_WAIT;
          wait_d    = clnws_pkg::POWER_ON_WAIT_MS;
        end
      endcase
    end

    nib = '0;
    en  = 1'b0;
    if (phase_d == clnws_pkg::PH_HIGH || phase_d == clnws_pkg::PH_SINGLE) begin
      nib = byte_d[7:4];
      en  = 1'b1;
    end else if (phase_d == clnws_pkg::PH_LOW) begin
      nib = byte_d[3:0];
      en  = 1'b1;
    end
    busy       = (phase_d != clnws_pkg::PH_IDLE);
    out_user_d = en && rs_d;
    out_data_d = {1'b0, rejected, busy, en, nib};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= clnws_pkg::PH_IDLE;
      wait_q      <= '0;
      byte_q      <= '0;
      rs_q        <= 1'b0;
      step_q      <= '0;
      in_init_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q   <= phase_d;
        wait_q    <= wait_d;
        byte_q    <= byte_d;
        rs_q      <= rs_d;
        step_q    <= step_d;
        in_init_q <= in_init_d;
      end
      if (q_pop_o) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

endmodule

@@ rtl/char_lcd_nibble_write_sequencer.sv @@
// Character LCD write sequencer for a 4-bit bus, timed by millisecond ticks.
// Slave-side stream: each request carries its kind in tuser (0 tick, 1 command
// byte, 2 data byte, 3 power-up init) and the byte in tdata. Every request,
// ticks included, yields exactly one result on the master-side stream: the
// level of the data lines, rs and enable after that request, plus busy and a
// rejected flag for a byte or init request that arrived while busy.
// An accepted request enters the queue; its result is registered in the back.
// Requests go through a two-entry queue into the sequencer, which retires one
// request per cycle while not stalled, so the block sustains one request per
// clock while the master side keeps tready high.
// When the receiver stalls, the held result stays on the port, the sequencer
// stops, and the queue fills; tready drops once both entries are taken.
// Reset clears the queue and the output valid flag and puts the sequencer in
// idle with no init in progress; the output data register is not reset.
module char_lcd_nibble_write_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // byte_value[7:0]
  input  logic [clnws_pkg::InDataW-1:0]     s_axis_tdata_i,
  // op[1:0]
  input  logic [clnws_pkg::OpW-1:0]         s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // data_nibble[3:0], enable_line[4], busy_res[5], rejected[6], zero[7]
  output logic [clnws_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // rs_line[0]
  output logic                              m_axis_tuser_o
);

  logic             q_full;
  logic             q_push;
  logic             q_valid;
  logic             q_pop;
  clnws_pkg::item_t q_wr_item;
  clnws_pkg::item_t q_rd_item;

  // The front types each request and pushes it while the queue has room.
  clnws_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_wr_item)
  );

  // The queue decouples request intake from the sequencer.
  clnws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_rd_item)
  );

  // The back holds the nibble sequencer state and the output register.
  clnws_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (q_rd_item),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

@@ rtl/clnws_checker.sv @@
module clnws_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [clnws_pkg::OutDataW-1:0]    m_axis_tdata_o,
  input logic                              m_axis_tuser_o
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // The enable strobe is only raised while a transfer is in progress.
  a_en_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[4] |-> m_axis_tdata_o[5])
    else $error("enable high while not busy");

  // rs is only driven alongside an enable strobe.
  a_rs_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[4])
    else $error("rs high without enable");

  // With no strobe the data lines rest at zero.
  a_lines_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[4] |-> m_axis_tdata_o[3:0] == 4'h0)
    else $error("data lines driven without enable");

  // A rejected request never leaves the block idle.
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[6] |-> m_axis_tdata_o[5])
    else $error("rejection reported while idle");

endmodule

bind char_lcd_nibble_write_sequencer clnws_checker u_clnws_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import clnws_pkg::*;

  localparam int unsigned TargetItems = 750;
  localparam int unsigned CalmAfter   = 650;
  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned DrainCycles = 8;

  // Display setup commands sent after the nibble part of the power-up sequence.
  localparam logic [ByteW-1:0] SETUP_CMDS [4] = '{8'h28, 8'h06, 8'h01, 8'h0F};

  typedef struct packed {
    logic [NibW-1:0] nib;
    logic            rs;
    logic            en;
    logic            busy;
    logic            rej;
  } lcd_lines_t;

  // Tracks the sequencer state and the line levels each request must produce.
  class lcd_line_board;
    phase_e           phase;
    logic [WaitW-1:0] wait_ms;
    logic [ByteW-1:0] held;
    logic             held_rs;
    logic [StepW-1:0] step;
    logic             in_init;
    lcd_lines_t       levels_q[$];
    int unsigned      errors;

    function new();
      phase   = PH_IDLE;
      wait_ms = '0;
      held    = '0;
      held_rs = 1'b0;
      step    = '0;
      in_init = 1'b0;
      errors  = 0;
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function void load_byte(logic [ByteW-1:0] b, logic rs);
      held    = b;
      held_rs = rs;
      phase   = PH_HIGH;
    endfunction

    // A wait has run out: move to the next power-up step or go idle.
    function void end_wait();
      logic [StepW-1:0] s;
      s = step;
      if (in_init && s < INIT_STEPS) begin
        step = s + 1'b1;
        if (s < INIT_NIBBLES) begin
          held    = (s == INIT_LAST_NIBBLE) ? INIT_NIB_4BIT : INIT_NIB_WAKE;
          held_rs = 1'b0;
          phase   = PH_SINGLE;
        end else begin
          load_byte(SETUP_CMDS[2'(s - INIT_NIBBLES)], 1'b0);
        end
      end else begin
        in_init = 1'b0;
        step    = '0;
        phase   = PH_IDLE;
      end
    endfunction

    function void advance_ms();
      case (phase)
        PH_WAIT: begin
          if (wait_ms <= 1) begin
            wait_ms = '0;
            end_wait();
          end else begin
            wait_ms = wait_ms - 1'b1;
          end
        end
        PH_HIGH: phase = PH_LOW;
        PH_LOW: begin
          phase   = PH_WAIT;
          wait_ms = (!held_rs && held < SLOW_CMD_LIMIT) ? WAIT_LONG_MS : WAIT_SHORT_MS;
        end
        PH_SINGLE: begin
          phase   = PH_WAIT;
          wait_ms = (step == 1) ? WAIT_FIRST_MS : WAIT_SHORT_MS;
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    // Notes an accepted request and queues the line levels it must produce.
    function void take_request(op_e op, logic [ByteW-1:0] b);
      lcd_lines_t want;
      bit         was_idle;
      was_idle = !busy();
      want     = '0;
      if (op == OP_TICK) begin
        if (!was_idle) advance_ms();
      end else if (!was_idle) begin
        want.rej = 1'b1;
      end else if (op == OP_CMD) begin
        load_byte(b, 1'b0);
      end else if (op == OP_DATA) begin
        load_byte(b, 1'b1);
      end else begin
        in_init = 1'b1;
        step    = '0;
        phase   = PH_WAIT;
        wait_ms = POWER_ON_WAIT_MS;
      end
      if (phase == PH_HIGH || phase == PH_SINGLE) begin
        want.nib = held[7:4];
        want.rs  = held_rs;
        want.en  = 1'b1;
      end else if (phase == PH_LOW) begin
        want.nib = held[3:0];
        want.rs  = held_rs;
        want.en  = 1'b1;
      end
      want.busy = busy();
      levels_q.push_back(want);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH %s", msg);
    endfunction

    function void match_result(logic [OutDataW-1:0] data, logic rs);
      lcd_lines_t want;
      if (levels_q.size() == 0) begin
        flag($sformatf("result with nothing pending: data=%h rs=%b", data, rs));
        return;
      end
      want = levels_q.pop_front();
      if (data[3:0] !== want.nib)
        flag($sformatf("data_nibble exp %h got %h", want.nib, data[3:0]));
      if (rs !== want.rs)
        flag($sformatf("rs_line exp %b got %b", want.rs, rs));
      if (data[4] !== want.en)
        flag($sformatf("enable_line exp %b got %b", want.en, data[4]));
      if (data[5] !== want.busy)
        flag($sformatf("busy exp %b got %b", want.busy, data[5]));
      if (data[6] !== want.rej)
        flag($sformatf("rejected exp %b got %b", want.rej, data[6]));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic [OpW-1:0]      s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  lcd_line_board board = new();
  bit            no_idle;
  int unsigned   sent;

  char_lcd_nibble_write_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one request at the falling edge and holds it until accepted.
  task automatic send_req(input op_e op, input logic [ByteW-1:0] b);
    int gap;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.take_request(op, b);
    sent++;
    if (sent % 64 == 0) no_idle = (sent >= CalmAfter) || ($urandom_range(0, 3) == 0);
    @(negedge clk_i);
  endtask

  task automatic tick_until_idle();
    while (board.busy()) send_req(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Receiver side: random stall bursts, none once the run is winding down.
  initial begin
    int hold;
    hold = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 18) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      board.match_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  // Ends the run when neither side has moved anything for too long.
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < StuckLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i))
        stuck = 0;
      else
        stuck++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int r;
    op_e op;
    logic [ByteW-1:0] b;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_TICK;
    no_idle         = 1'b0;
    sent            = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: idle tick, slow and fast commands, data extremes,
    // requests while busy, and a power-up sequence left running.
    send_req(OP_TICK, 8'h00);
    send_req(OP_CMD, 8'h00);
    send_req(OP_DATA, 8'hFF);
    send_req(OP_INIT, 8'h55);
    tick_until_idle();
    send_req(OP_DATA, 8'hFF);
    tick_until_idle();
    send_req(OP_CMD, 8'h04);
    tick_until_idle();
    send_req(OP_DATA, 8'h00);
    tick_until_idle();
    send_req(OP_INIT, 8'h00);
    send_req(OP_CMD, 8'hFF);

    // Random part: mostly well-formed traffic, with some requests thrown
    // at a busy sequencer.
    while (sent < TargetItems) begin
      b = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 19);
      if (board.busy()) begin
        op = (r < 17) ? OP_TICK : op_e'($urandom_range(1, 3));
      end else begin
        if (r < 9) begin
          op = OP_CMD;
          if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(0, 7));
        end else if (r < 16) begin
          op = OP_DATA;
        end else if (r < 18) begin
          op = OP_INIT;
        end else begin
          op = OP_TICK;
        end
      end
      send_req(op, b);
    end
    s_axis_tvalid_i <= 1'b0;

    while (board.levels_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/clnws_pkg.sv
rtl/clnws_front.sv
rtl/clnws_queue.sv
rtl/clnws_back.sv
rtl/char_lcd_nibble_write_sequencer.sv
rtl/clnws_checker.sv
tb/sv/tb_top.sv
